FILE: rtl/mws_pkg.sv
// Shared types and constants for the maximum window sum block.
// No dependencies; imported by every module under rtl/.
`default_nettype none

package mws_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int BEST_W       = 23;
  localparam int ROWS_REG_W   = 13;
  localparam int COLS_REG_W   = 11;
  localparam int WIN_REG_W    = 5;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int ROWS_LIMIT   = 4096;
  localparam int ROW_CNT_W    = 12;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 24;

  localparam int DEF_MAX_COLS     = 1024;
  localparam int DEF_MAX_WIN_ROWS = 16;
  localparam int DEF_MAX_WIN_COLS = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATRIX_ROWS = 2'd0,
    REG_MATRIX_COLS = 2'd1,
    REG_WINDOW_ROWS = 2'd2,
    REG_WINDOW_COLS = 2'd3
  } cfg_reg_e;

  // Per-sample control that travels down the pipeline with the data
  typedef struct packed {
    logic first_row;   // first matrix row: column sum restarts
    logic sub_hist;    // drop the sample that left the window vertically
    logic first_col;   // first column: horizontal sum restarts
    logic sub_recent;  // drop the column sum that left the window horizontally
    logic win_full;    // a complete window ends at this sample
    logic last;        // last sample of the matrix
  } item_flags_t;

endpackage

`default_nettype wire

FILE: rtl/mws_ctrl.sv
// Configuration registers and raster position counters.
// Depends on mws_pkg; produces memory addresses and per-sample flags.
`default_nettype none

module mws_ctrl import mws_pkg::*; #(
  parameter int MAX_COLS     = DEF_MAX_COLS,
  parameter int MAX_WIN_ROWS = DEF_MAX_WIN_ROWS,
  parameter int MAX_WIN_COLS = DEF_MAX_WIN_COLS,
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int SLOT_W = (MAX_WIN_ROWS > 1) ? $clog2(MAX_WIN_ROWS) : 1,
  localparam int RIDX_W = (MAX_WIN_COLS > 1) ? $clog2(MAX_WIN_COLS) : 1,
  localparam int HA_W   = (MAX_WIN_ROWS * MAX_COLS > 1) ? $clog2(MAX_WIN_ROWS * MAX_COLS) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  adv,
  output logic [COL_W-1:0]           cur_col,
  output logic [HA_W-1:0]            cur_haddr,
  output logic [RIDX_W-1:0]          cur_ridx,
  output item_flags_t                cur_flags
);

  localparam int CCNT_W = $clog2(MAX_COLS + 1);
  localparam int WR_W   = $clog2(MAX_WIN_ROWS + 1);
  localparam int WC_W   = $clog2(MAX_WIN_COLS + 1);

  logic [ROWS_REG_W-1:0] rows_r;
  logic [CCNT_W-1:0]     cols_r;
  logic [WR_W-1:0]       wr_r;
  logic [WC_W-1:0]       wc_r;

  logic [COL_W-1:0]      col_r, col_nxt;
  logic [ROW_CNT_W-1:0]  row_r, row_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [RIDX_W-1:0]     ridx_r, ridx_nxt;

  logic [COLS_REG_W-1:0] cols_raw;
  logic [WIN_REG_W-1:0]  win_raw;
  logic                  col_end;
  logic                  row_end;

  assign cols_raw = cfg_wdata[COLS_REG_W-1:0];
  assign win_raw  = cfg_wdata[WIN_REG_W-1:0];

  // Registers hold clamped values: zero counts as one, oversize as the maximum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_REG_W'(1);
      cols_r <= CCNT_W'(1);
      wr_r   <= WR_W'(1);
      wc_r   <= WC_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_MATRIX_ROWS: begin
          if (cfg_wdata == '0)                 rows_r <= ROWS_REG_W'(1);
          else if (int'(cfg_wdata) > ROWS_LIMIT) rows_r <= ROWS_REG_W'(ROWS_LIMIT);
          else                                 rows_r <= cfg_wdata;
        end
        REG_MATRIX_COLS: begin
          if (cols_raw == '0)                  cols_r <= CCNT_W'(1);
          else if (int'(cols_raw) > MAX_COLS)  cols_r <= CCNT_W'(MAX_COLS);
          else                                 cols_r <= CCNT_W'(cols_raw);
        end
        REG_WINDOW_ROWS: begin
          if (win_raw == '0)                      wr_r <= WR_W'(1);
          else if (int'(win_raw) > MAX_WIN_ROWS)  wr_r <= WR_W'(MAX_WIN_ROWS);
          else                                    wr_r <= WR_W'(win_raw);
        end
        REG_WINDOW_COLS: begin
          if (win_raw == '0)                      wc_r <= WC_W'(1);
          else if (int'(win_raw) > MAX_WIN_COLS)  wc_r <= WC_W'(MAX_WIN_COLS);
          else                                    wc_r <= WC_W'(win_raw);
        end
        default: begin
          rows_r <= rows_r;
        end
      endcase
    end
  end

  assign col_end = (int'(col_r) + 1) == int'(cols_r);
  assign row_end = (int'(row_r) + 1) == int'(rows_r);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    ridx_nxt = ridx_r;
    if (cfg_we) begin
      col_nxt  = '0;
      row_nxt  = '0;
      slot_nxt = '0;
      ridx_nxt = '0;
    end else if (adv) begin
      if (col_end) begin
        col_nxt  = '0;
        ridx_nxt = '0;
        if (row_end) begin
          row_nxt  = '0;
          slot_nxt = '0;
        end else begin
          row_nxt  = row_r + ROW_CNT_W'(1);
          slot_nxt = ((int'(slot_r) + 1) == int'(wr_r)) ? '0 : slot_r + SLOT_W'(1);
        end
      end else begin
        col_nxt  = col_r + COL_W'(1);
        ridx_nxt = ((int'(ridx_r) + 1) == int'(wc_r)) ? '0 : ridx_r + RIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
      ridx_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
      ridx_r <= ridx_nxt;
    end
  end

  assign cur_col   = col_r;
  assign cur_ridx  = ridx_r;
  assign cur_haddr = HA_W'(int'(slot_r) * MAX_COLS + int'(col_r));

  always_comb begin
    cur_flags.first_row  = (row_r == '0);
    cur_flags.sub_hist   = int'(row_r) >= int'(wr_r);
    cur_flags.first_col  = (col_r == '0);
    cur_flags.sub_recent = int'(col_r) >= int'(wc_r);
    cur_flags.win_full   = ((int'(row_r) + 1) >= int'(wr_r)) &&
                           ((int'(col_r) + 1) >= int'(wc_r));
    cur_flags.last       = col_end && row_end;
  end

endmodule

`default_nettype wire

FILE: rtl/mws_colsum.sv
// Vertical stage: row history and column sum memories with read-modify-write.
// Depends on mws_pkg; fed by mws_ctrl, feeds mws_hsum.
`default_nettype none

module mws_colsum import mws_pkg::*; #(
  parameter int MAX_COLS     = DEF_MAX_COLS,
  parameter int MAX_WIN_ROWS = DEF_MAX_WIN_ROWS,
  parameter int MAX_WIN_COLS = DEF_MAX_WIN_COLS,
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RIDX_W = (MAX_WIN_COLS > 1) ? $clog2(MAX_WIN_COLS) : 1,
  localparam int HA_W   = (MAX_WIN_ROWS * MAX_COLS > 1) ? $clog2(MAX_WIN_ROWS * MAX_COLS) : 1,
  localparam int CS_W   = SAMPLE_W + $clog2(MAX_WIN_ROWS) + 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       acc,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic [COL_W-1:0]           col,
  input  wire logic [HA_W-1:0]            haddr,
  input  wire logic [RIDX_W-1:0]          ridx,
  input  wire item_flags_t                flags,
  output logic                            cs_valid,
  output logic signed [CS_W-1:0]          cs_sum,
  output logic [RIDX_W-1:0]               cs_ridx,
  output item_flags_t                     cs_flags
);

  localparam int HDEPTH = MAX_WIN_ROWS * MAX_COLS;

  logic signed [CS_W-1:0]     colsum_mem [MAX_COLS];
  logic signed [SAMPLE_W-1:0] hist_mem   [HDEPTH];

  logic                       s1_valid_r;
  logic [COL_W-1:0]           s1_col_r;
  logic [HA_W-1:0]            s1_haddr_r;
  logic [RIDX_W-1:0]          s1_ridx_r;
  item_flags_t                s1_flags_r;
  logic signed [SAMPLE_W-1:0] s1_x_r;

  logic signed [CS_W-1:0]     colsum_q_r;
  logic signed [SAMPLE_W-1:0] hist_q_r;
  logic                       cs_hit_r;
  logic signed [CS_W-1:0]     cs_fwd_r;
  logic                       hist_hit_r;
  logic signed [SAMPLE_W-1:0] hist_fwd_r;

  logic                       s2_valid_r;
  logic signed [CS_W-1:0]     s2_cs_r;
  logic [RIDX_W-1:0]          s2_ridx_r;
  item_flags_t                s2_flags_r;

  logic signed [CS_W-1:0]     colsum_v;
  logic signed [SAMPLE_W-1:0] hist_v;
  logic signed [CS_W-1:0]     cs;

  // Memories: read at accept, write back in the following cycle
  always_ff @(posedge clk) begin
    colsum_q_r <= colsum_mem[col];
    hist_q_r   <= hist_mem[haddr];
    if (s1_valid_r) begin
      colsum_mem[s1_col_r] <= cs;
      hist_mem[s1_haddr_r] <= s1_x_r;
    end
  end

  // Forward the write-back that coincides with the read of the same entry
  always_ff @(posedge clk) begin
    cs_fwd_r   <= cs;
    hist_fwd_r <= s1_x_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_hit_r   <= 1'b0;
      hist_hit_r <= 1'b0;
    end else begin
      cs_hit_r   <= s1_valid_r && (s1_col_r == col);
      hist_hit_r <= s1_valid_r && (s1_haddr_r == haddr);
    end
  end

  assign colsum_v = cs_hit_r   ? cs_fwd_r   : colsum_q_r;
  assign hist_v   = hist_hit_r ? hist_fwd_r : hist_q_r;

  always_comb begin
    if (s1_flags_r.first_row) begin
      cs = CS_W'(s1_x_r);
    end else begin
      cs = colsum_v + CS_W'(s1_x_r) - (s1_flags_r.sub_hist ? CS_W'(hist_v) : CS_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col_r   <= col;
      s1_haddr_r <= haddr;
      s1_ridx_r  <= ridx;
      s1_flags_r <= flags;
      s1_x_r     <= sample;
    end
    s2_cs_r    <= cs;
    s2_ridx_r  <= s1_ridx_r;
    s2_flags_r <= s1_flags_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= acc;
      s2_valid_r <= s1_valid_r;
    end
  end

  assign cs_valid = s2_valid_r;
  assign cs_sum   = s2_cs_r;
  assign cs_ridx  = s2_ridx_r;
  assign cs_flags = s2_flags_r;

endmodule

`default_nettype wire

FILE: rtl/mws_hsum.sv
// Horizontal stage: running window sum, best-sum tracking and result register.
// Depends on mws_pkg; fed by mws_colsum.
`default_nettype none

module mws_hsum import mws_pkg::*; #(
  parameter int MAX_WIN_ROWS = DEF_MAX_WIN_ROWS,
  parameter int MAX_WIN_COLS = DEF_MAX_WIN_COLS,
  localparam int RIDX_W = (MAX_WIN_COLS > 1) ? $clog2(MAX_WIN_COLS) : 1,
  localparam int CS_W   = SAMPLE_W + $clog2(MAX_WIN_ROWS) + 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic                   cs_valid,
  input  wire logic signed [CS_W-1:0] cs_sum,
  input  wire logic [RIDX_W-1:0]      cs_ridx,
  input  wire item_flags_t            cs_flags,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output logic [BEST_W-1:0]           out_best
);

  localparam int WS_RAW = CS_W + $clog2(MAX_WIN_COLS) + 1;
  localparam int WS_W   = (WS_RAW > BEST_W) ? WS_RAW : BEST_W + 1;

  logic signed [CS_W-1:0] recent_r [MAX_WIN_COLS];
  logic signed [WS_W-1:0] ws_r;
  logic signed [WS_W-1:0] ws_nxt;
  logic signed [WS_W-1:0] best_r;
  logic signed [WS_W-1:0] best_nxt;

  logic                   s3_valid_r;
  logic                   s3_full_r;
  logic                   s3_last_r;
  logic                   out_valid_r;
  logic [BEST_W-1:0]      out_best_r;

  assign ws_nxt = (cs_flags.first_col ? WS_W'(0) : ws_r) + WS_W'(cs_sum) -
                  (cs_flags.sub_recent ? WS_W'(recent_r[cs_ridx]) : WS_W'(0));

  always_ff @(posedge clk) begin
    if (cs_valid) begin
      ws_r              <= ws_nxt;
      recent_r[cs_ridx] <= cs_sum;
    end
    s3_full_r <= cs_flags.win_full;
    s3_last_r <= cs_flags.last;
  end

  assign best_nxt = (s3_full_r && (ws_r > best_r)) ? ws_r : best_r;

  always_ff @(posedge clk) begin
    if (s3_valid_r && s3_last_r) begin
      out_best_r <= best_nxt[BEST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= cs_valid;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        best_r <= '0;
      end else if (s3_valid_r) begin
        // End of matrix: publish and restart the best sum
        if (s3_last_r) begin
          best_r      <= '0;
          out_valid_r <= 1'b1;
        end else begin
          best_r <= best_nxt;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_best  = out_best_r;

endmodule

`default_nettype wire

FILE: rtl/max_window_sum_2d.sv
// Largest sum over every window_rows x window_cols window of a signed matrix
// (zero if no window sum is positive) that arrives one sample per transaction
// in raster order. One sample is accepted per clock unless the last sample of
// a matrix is held off; a sample passes a read of the column sum and row
// history memories, their write-back in the following cycle (forwarded when
// consecutive samples hit the same entry), then the horizontal running sum
// and the best-sum compare that loads the result register, which holds one
// best_sum; the last sample of a matrix is held off while the previous result
// is still in flight or not yet taken. No clearing pass after reset.
// Depends on mws_pkg, mws_ctrl, mws_colsum and mws_hsum.
`default_nettype none

module max_window_sum_2d import mws_pkg::*; #(
  parameter int MAX_COLS     = DEF_MAX_COLS,
  parameter int MAX_WIN_ROWS = DEF_MAX_WIN_ROWS,
  parameter int MAX_WIN_COLS = DEF_MAX_WIN_COLS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,    // [15:0] sample
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,   // [22:0] best_sum, [23] zero
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RIDX_W = (MAX_WIN_COLS > 1) ? $clog2(MAX_WIN_COLS) : 1;
  localparam int HA_W   = (MAX_WIN_ROWS * MAX_COLS > 1) ? $clog2(MAX_WIN_ROWS * MAX_COLS) : 1;
  localparam int CS_W   = SAMPLE_W + $clog2(MAX_WIN_ROWS) + 1;

  logic [COL_W-1:0]       cur_col;
  logic [HA_W-1:0]        cur_haddr;
  logic [RIDX_W-1:0]      cur_ridx;
  item_flags_t            cur_flags;

  logic                   cs_valid;
  logic signed [CS_W-1:0] cs_sum;
  logic [RIDX_W-1:0]      cs_ridx;
  item_flags_t            cs_flags;

  logic                   res_valid;
  logic [BEST_W-1:0]      res_best;
  logic [2:0]             last_pipe_r;
  logic                   acc;

  // A last sample waits until no earlier result can still occupy the output
  assign in_tready = !cur_flags.last ||
                     ((last_pipe_r == '0) && (!res_valid || out_tready));
  assign acc       = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pipe_r <= '0;
    end else begin
      last_pipe_r <= {last_pipe_r[1:0], acc && cur_flags.last};
    end
  end

  mws_ctrl #(
    .MAX_COLS     (MAX_COLS),
    .MAX_WIN_ROWS (MAX_WIN_ROWS),
    .MAX_WIN_COLS (MAX_WIN_COLS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .adv       (acc),
    .cur_col   (cur_col),
    .cur_haddr (cur_haddr),
    .cur_ridx  (cur_ridx),
    .cur_flags (cur_flags)
  );

  mws_colsum #(
    .MAX_COLS     (MAX_COLS),
    .MAX_WIN_ROWS (MAX_WIN_ROWS),
    .MAX_WIN_COLS (MAX_WIN_COLS)
  ) u_colsum (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .sample   (in_tdata[SAMPLE_W-1:0]),
    .col      (cur_col),
    .haddr    (cur_haddr),
    .ridx     (cur_ridx),
    .flags    (cur_flags),
    .cs_valid (cs_valid),
    .cs_sum   (cs_sum),
    .cs_ridx  (cs_ridx),
    .cs_flags (cs_flags)
  );

  mws_hsum #(
    .MAX_WIN_ROWS (MAX_WIN_ROWS),
    .MAX_WIN_COLS (MAX_WIN_COLS)
  ) u_hsum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cs_valid  (cs_valid),
    .cs_sum    (cs_sum),
    .cs_ridx   (cs_ridx),
    .cs_flags  (cs_flags),
    .out_ready (out_tready),
    .out_valid (res_valid),
    .out_best  (res_best)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {{(OUT_TDATA_W - BEST_W){1'b0}}, res_best};

endmodule

`default_nettype wire
